// ===== design/i2cbs_pkg.sv =====
// Shared types and constants for the two-wire bus master bit sequencer.
// No dependencies; imported by i2cbs_step and i2c_master_bit_sequencer.
`default_nettype none

package i2cbs_pkg;

  localparam int unsigned RECOVERY_CLOCKS = 9;
  localparam int unsigned PHASE_W         = 3;
  localparam int unsigned TICK_W          = 16;
  localparam int unsigned UNITS_W         = 3;
  localparam logic [TICK_W-1:0] TICKS_RESET = 16'd100;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4,
    CMD_SENSOR  = 3'd5,
    CMD_RECOVER = 3'd6
  } cmd_e_t;

  // Line levels and hold length of one step of a command.
  typedef struct packed {
    logic               scl;
    logic               sda;
    logic               drv;
    logic [UNITS_W-1:0] units;
  } step_t;

endpackage

`default_nettype wire

// ===== design/i2cbs_step.sv =====
// Step table: line levels and hold length for a command at a given phase.
// Depends on i2cbs_pkg.
`default_nettype none

module i2cbs_step (
  input  var i2cbs_pkg::cmd_e_t                cmd,
  input  var logic [i2cbs_pkg::PHASE_W-1:0]    phase,
  input  var logic                             tx_bit,
  input  var logic                             nack,
  output i2cbs_pkg::step_t                     step
);
  import i2cbs_pkg::*;

  localparam logic [2:0] ST_SCL = 3'b011;  // bit i is phase i
  localparam logic [2:0] ST_SDA = 3'b001;
  localparam logic [2:0] ST_UN1 = 3'b011;
  localparam logic [6:0] SS_SCL = 7'b0110110;
  localparam logic [6:0] SS_SDA = 7'b1100011;
  localparam logic [2:0] SP_SCL = 3'b110;
  localparam logic [2:0] SP_SDA = 3'b100;

  logic [PHASE_W-1:0] p2;
  logic [PHASE_W-1:0] p6;
  logic               c;
  logic               d;
  logic               drv;
  logic [UNITS_W-1:0] u;

  assign p2 = (phase > PHASE_W'(2)) ? PHASE_W'(2) : phase;
  assign p6 = (phase > PHASE_W'(6)) ? PHASE_W'(6) : phase;

  always_comb begin
    c   = 1'b0;
    d   = 1'b1;
    drv = 1'b1;
    u   = UNITS_W'(1);
    unique case (cmd)
      CMD_START: begin
        c = ST_SCL[p2[1:0]];
        d = ST_SDA[p2[1:0]];
        u = ST_UN1[p2[1:0]] ? UNITS_W'(1) : UNITS_W'(0);
      end
      CMD_SENSOR: begin
        c = SS_SCL[p6];
        d = SS_SDA[p6];
        unique case (p6)
          3'd3:    u = UNITS_W'(3);
          3'd6:    u = UNITS_W'(0);
          default: u = UNITS_W'(1);
        endcase
      end
      CMD_STOP: begin
        c = SP_SCL[p2[1:0]];
        d = SP_SDA[p2[1:0]];
        u = UNITS_W'(1);
      end
      CMD_WRITE: begin
        unique case (phase)
          3'd0:    begin c = 1'b0; d = tx_bit; u = UNITS_W'(2); end
          3'd1:    begin c = 1'b1; d = tx_bit; u = UNITS_W'(4); end
          3'd2:    begin c = 1'b0; d = tx_bit; u = UNITS_W'(2); end
          3'd3:    begin c = 1'b1; drv = 1'b0; u = UNITS_W'(1); end
          default: begin c = 1'b0; drv = 1'b0; u = UNITS_W'(0); end
        endcase
      end
      CMD_READ: begin
        unique case (phase)
          3'd0:    begin c = 1'b1; drv = 1'b0; u = UNITS_W'(3); end
          3'd1:    begin c = 1'b0; drv = 1'b0; u = UNITS_W'(2); end
          3'd2:    begin c = 1'b0; d = nack;   u = UNITS_W'(1); end
          3'd3:    begin c = 1'b1; d = nack;   u = UNITS_W'(2); end
          default: begin c = 1'b0; d = nack;   u = UNITS_W'(0); end
        endcase
      end
      default: begin
        // recovery: lead-in low, then clock pulses high on phase one
        c = (phase == PHASE_W'(1));
        u = UNITS_W'(1);
      end
    endcase
  end

  // A released line reads back as high.
  assign step.scl   = c;
  assign step.sda   = drv ? d : 1'b1;
  assign step.drv   = drv;
  assign step.units = u;

endmodule

`default_nettype wire

// ===== design/i2c_master_bit_sequencer.sv =====
// Top level of the two-wire bus master bit sequencer.
// Depends on i2cbs_pkg and i2cbs_step.
//
//   Channel   Ports                                  Content
//   input     in_tvalid/in_tready/in_tdata/in_tuser   one tick, optional command
//   result    out_tvalid/out_tready/out_tdata         line levels and status
//   config    cfg_wr_en/cfg_wr_data                   ticks_per_unit
//
// One request is taken every cycle; its result is registered and offered on
// the next cycle. A stalled result holds; the input keeps flowing while the
// result register is empty or being emptied in the same cycle.
// Synchronous active-low reset gives ticks_per_unit 100, idle, SCL low,
// SDA driven high.
`default_nettype none

module i2c_master_bit_sequencer (
  input  var logic        clk,
  input  var logic        rst_n,
  input  var logic        in_tvalid,
  output logic            in_tready,
  input  var logic [15:0] in_tdata,   // tx_byte[7:0], ack_level[8], sda_in[9], zero
  input  var logic [2:0]  in_tuser,   // kind[2:0]
  output logic            out_tvalid,
  input  var logic        out_tready,
  output logic [15:0]     out_tdata,  // scl_level, sda_level, sda_drive, busy_res,
                                      // done_res, rx_byte[12:5], ack_seen[13], zero
  input  var logic        cfg_wr_en,
  input  var logic [15:0] cfg_wr_data
);
  import i2cbs_pkg::*;

  localparam logic [4:0] REC_LAST = 5'(RECOVERY_CLOCKS);

  logic [TICK_W-1:0]  tpu_r;
  cmd_e_t             cmd_r, cmd_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TICK_W-1:0]  delay_r, delay_nxt;
  logic [UNITS_W-1:0] units_r, units_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [7:0]         rx_r, rx_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               drv_r, drv_nxt;
  logic               ack_r, ack_nxt;
  logic               nack_r, nack_nxt;
  logic               done_nxt;
  logic               enter;
  logic               finish;
  logic               out_tvalid_r;
  logic [15:0]        out_tdata_r;
  logic               accept;
  logic [TICK_W-1:0]  tick_m1;
  step_t              step;

  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       ack_level;
  logic       sda_in;

  assign kind      = in_tuser;
  assign tx_byte   = in_tdata[7:0];
  assign ack_level = in_tdata[8];
  assign sda_in    = in_tdata[9];

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign tick_m1   = (tpu_r == '0) ? '0 : tpu_r - TICK_W'(1);

  // Sequencing: start a command, or advance to the next step or finish once both step timers have run out.
  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    rx_nxt    = rx_r;
    ack_nxt   = ack_r;
    nack_nxt  = nack_r;
    enter     = 1'b0;
    finish    = 1'b0;
    if (cmd_r == CMD_NONE) begin
      if (kind != 3'd0 && kind != 3'd7) begin
        cmd_nxt   = cmd_e_t'(kind);
        phase_nxt = '0;
        bit_nxt   = '0;
        shift_nxt = (cmd_e_t'(kind) == CMD_WRITE) ? tx_byte : 8'd0;
        nack_nxt  = ack_level;
        enter     = 1'b1;
      end
    end else if (delay_r == '0 && units_r == '0) begin
      unique case (cmd_r)
        CMD_START, CMD_STOP: begin
          if (phase_r >= PHASE_W'(2)) finish = 1'b1;
          else phase_nxt = phase_r + PHASE_W'(1);
        end
        CMD_SENSOR: begin
          if (phase_r >= PHASE_W'(6)) finish = 1'b1;
          else phase_nxt = phase_r + PHASE_W'(1);
        end
        CMD_WRITE: begin
          case (phase_r) inside
            3'd0, 3'd1: phase_nxt = phase_r + PHASE_W'(1);
            3'd2: begin
              shift_nxt = {shift_r[6:0], 1'b0};
              if (bit_r >= 4'd7) begin
                phase_nxt = PHASE_W'(3);
              end else begin
                bit_nxt   = bit_r + 4'd1;
                phase_nxt = '0;
              end
            end
            3'd3: begin
              ack_nxt   = sda_in;
              phase_nxt = PHASE_W'(4);
            end
            default: finish = 1'b1;
          endcase
        end
        CMD_READ: begin
          case (phase_r) inside
            3'd0: begin
              shift_nxt = {shift_r[6:0], sda_in};
              phase_nxt = PHASE_W'(1);
            end
            3'd1: begin
              if (bit_r >= 4'd7) begin
                rx_nxt    = shift_r;
                phase_nxt = PHASE_W'(2);
              end else begin
                bit_nxt   = bit_r + 4'd1;
                phase_nxt = '0;
              end
            end
            3'd2, 3'd3: phase_nxt = phase_r + PHASE_W'(1);
            default:    finish = 1'b1;
          endcase
        end
        CMD_RECOVER: begin
          case (phase_r) inside
            3'd0, 3'd1: phase_nxt = phase_r + PHASE_W'(1);
            default: begin
              // after the last recovery clock, hand over to a sensor start
              if ({1'b0, bit_r} + 5'd1 >= REC_LAST) begin
                cmd_nxt   = CMD_SENSOR;
                phase_nxt = '0;
              end else begin
                bit_nxt   = bit_r + 4'd1;
                phase_nxt = PHASE_W'(1);
              end
            end
          endcase
        end
        default: ;
      endcase
      if (finish) begin
        cmd_nxt   = CMD_NONE;
        phase_nxt = '0;
      end else begin
        enter = 1'b1;
      end
    end
  end

  i2cbs_step u_step (
    .cmd    (cmd_nxt),
    .phase  (phase_nxt),
    .tx_bit (shift_nxt[7]),
    .nack   (nack_nxt),
    .step   (step)
  );

  // Line levels and step timers.
  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    delay_nxt = delay_r;
    units_nxt = units_r;
    done_nxt  = finish;
    if (cmd_r != CMD_NONE && delay_r != '0) begin
      delay_nxt = delay_r - TICK_W'(1);
    end else if (cmd_r != CMD_NONE && units_r != '0) begin
      units_nxt = units_r - UNITS_W'(1);
      delay_nxt = tick_m1;
    end
    if (enter) begin
      scl_nxt = step.scl;
      sda_nxt = step.sda;
      drv_nxt = step.drv;
      if (step.units == '0) begin
        delay_nxt = '0;
        units_nxt = '0;
      end else begin
        delay_nxt = tick_m1;
        units_nxt = step.units - UNITS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= TICKS_RESET;
    end else if (cfg_wr_en) begin
      tpu_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_NONE;
      phase_r <= '0;
      delay_r <= '0;
      units_r <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      rx_r    <= '0;
      scl_r   <= 1'b0;
      sda_r   <= 1'b1;
      drv_r   <= 1'b1;
      ack_r   <= 1'b0;
      nack_r  <= 1'b0;
    end else if (accept) begin
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      delay_r <= delay_nxt;
      units_r <= units_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      rx_r    <= rx_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      drv_r   <= drv_nxt;
      ack_r   <= ack_nxt;
      nack_r  <= nack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= {2'b00, ack_nxt, rx_nxt, done_nxt, (cmd_nxt != CMD_NONE),
                      drv_nxt, sda_nxt, scl_nxt};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Idle implies both step timers have run out.
  a_idle_timers: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r == CMD_NONE |-> (delay_r == '0 && units_r == '0))
    else $error("timers running while idle");

  // A done pulse only ends a command that was running.
  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done_nxt |-> cmd_r != CMD_NONE && cmd_nxt == CMD_NONE)
    else $error("done without a running command");

  // Every request leaves a result behind.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid_r)
    else $error("request without result");

  // Released SDA always reads back high.
  a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
    !drv_r |-> sda_r)
    else $error("released SDA not high");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the two-wire bus master bit sequencer.
// Drives tick requests with optional commands, predicts every result in-line
// and compares field by field. Depends on i2cbs_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module testbench;
  import i2cbs_pkg::*;

  localparam int unsigned CLK_PERIOD  = 4;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [2:0]  KIND_UNUSED = 3'd7;

  // Result fields, lowest bit first from the bottom up.
  typedef struct packed {
    logic [1:0] pad;
    logic       ack;
    logic [7:0] rx;
    logic       done;
    logic       busy;
    logic       drv;
    logic       sda;
    logic       scl;
  } levels_t;

  typedef struct packed {
    logic        is_cfg;
    logic [15:0] value;
    logic [2:0]  kind;
    logic [7:0]  tx;
    logic        ackl;
    logic        sda;
    logic [15:0] reps;
    logic        has_want;
    levels_t     want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // tx_byte[7:0], ack_level[8], sda_in[9], zero
  logic [2:0]  in_tuser;    // kind[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;   // scl, sda, drive, busy, done, rx_byte[12:5], ack_seen[13]
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;

  levels_t   levels_due [$];
  plan_row_t plan [$];
  levels_t   seen_lv, due_lv;

  // Predicted sequencer state.
  cmd_e_t      seq_cmd;
  logic [5:0]  seq_phase;
  logic [15:0] seq_delay;
  logic [2:0]  seq_units;
  logic [3:0]  seq_bits;
  logic [7:0]  seq_shift;
  logic [7:0]  seq_rx;
  logic        seq_scl, seq_sda, seq_drv, seq_ack, seq_nack;
  logic [15:0] seq_ticks;

  i2c_master_bit_sequencer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic levels_t bus_lines(input logic scl, input logic sda, input logic drv,
                                        input logic busy);
    levels_t lv;
    lv      = '0;
    lv.scl  = scl;
    lv.sda  = sda;
    lv.drv  = drv;
    lv.busy = busy;
    return lv;
  endfunction

  function automatic logic [15:0] unit_ticks();
    return (seq_ticks == 16'd0) ? 16'd1 : seq_ticks;
  endfunction

  task automatic drive_lines(input logic c, input logic d, input logic dr);
    seq_scl = c;
    seq_drv = dr;
    seq_sda = dr ? d : 1'b1;
  endtask

  // Set the line levels of the current step and give its length in units.
  task automatic step_hold(output int unsigned units);
    logic [5:0] p;
    p = seq_phase;
    case (seq_cmd)
      CMD_START: begin
        case (p)
          6'd0: begin drive_lines(1'b1, 1'b1, 1'b1); units = 1; end
          6'd1: begin drive_lines(1'b1, 1'b0, 1'b1); units = 1; end
          default: begin drive_lines(1'b0, 1'b0, 1'b1); units = 0; end
        endcase
      end
      CMD_SENSOR: begin
        case (p)
          6'd0: begin drive_lines(1'b0, 1'b1, 1'b1); units = 1; end
          6'd1: begin drive_lines(1'b1, 1'b1, 1'b1); units = 1; end
          6'd2: begin drive_lines(1'b1, 1'b0, 1'b1); units = 1; end
          6'd3: begin drive_lines(1'b0, 1'b0, 1'b1); units = 3; end
          6'd4: begin drive_lines(1'b1, 1'b0, 1'b1); units = 1; end
          6'd5: begin drive_lines(1'b1, 1'b1, 1'b1); units = 1; end
          default: begin drive_lines(1'b0, 1'b1, 1'b1); units = 0; end
        endcase
      end
      CMD_STOP: begin
        case (p)
          6'd0: begin drive_lines(1'b0, 1'b0, 1'b1); units = 1; end
          6'd1: begin drive_lines(1'b1, 1'b0, 1'b1); units = 1; end
          default: begin drive_lines(1'b1, 1'b1, 1'b1); units = 1; end
        endcase
      end
      CMD_WRITE: begin
        case (p)
          6'd0: begin drive_lines(1'b0, seq_shift[7], 1'b1); units = 2; end
          6'd1: begin drive_lines(1'b1, seq_shift[7], 1'b1); units = 4; end
          6'd2: begin drive_lines(1'b0, seq_shift[7], 1'b1); units = 2; end
          6'd3: begin drive_lines(1'b1, 1'b1, 1'b0); units = 1; end
          default: begin drive_lines(1'b0, 1'b1, 1'b0); units = 0; end
        endcase
      end
      CMD_READ: begin
        case (p)
          6'd0: begin drive_lines(1'b1, 1'b1, 1'b0); units = 3; end
          6'd1: begin drive_lines(1'b0, 1'b1, 1'b0); units = 2; end
          6'd2: begin drive_lines(1'b0, seq_nack, 1'b1); units = 1; end
          6'd3: begin drive_lines(1'b1, seq_nack, 1'b1); units = 2; end
          default: begin drive_lines(1'b0, seq_nack, 1'b1); units = 0; end
        endcase
      end
      default: begin
        // recovery clocks: high on phase one, low otherwise
        drive_lines(p == 6'd1, 1'b1, 1'b1);
        units = 1;
      end
    endcase
  endtask

  task automatic enter_step();
    int unsigned u;
    step_hold(u);
    if (u == 0) begin
      seq_delay = '0;
      seq_units = '0;
    end else begin
      seq_delay = unit_ticks() - 16'd1;
      seq_units = 3'(u - 1);
    end
  endtask

  // End the current step; flag when the command is complete.
  task automatic advance(input logic sda, output logic fin);
    fin = 1'b0;
    case (seq_cmd)
      CMD_START, CMD_STOP: begin
        if (seq_phase >= 6'd2) fin = 1'b1;
        else seq_phase++;
      end
      CMD_SENSOR: begin
        if (seq_phase >= 6'd6) fin = 1'b1;
        else seq_phase++;
      end
      CMD_WRITE: begin
        if (seq_phase <= 6'd1) begin
          seq_phase++;
        end else if (seq_phase == 6'd2) begin
          seq_shift = {seq_shift[6:0], 1'b0};
          if (seq_bits >= 4'd7) begin
            seq_phase = 6'd3;
          end else begin
            seq_bits++;
            seq_phase = 6'd0;
          end
        end else if (seq_phase == 6'd3) begin
          seq_ack   = sda;
          seq_phase = 6'd4;
        end else begin
          fin = 1'b1;
        end
      end
      CMD_READ: begin
        if (seq_phase == 6'd0) begin
          seq_shift = {seq_shift[6:0], sda};
          seq_phase = 6'd1;
        end else if (seq_phase == 6'd1) begin
          if (seq_bits >= 4'd7) begin
            seq_rx    = seq_shift;
            seq_phase = 6'd2;
          end else begin
            seq_bits++;
            seq_phase = 6'd0;
          end
        end else if (seq_phase <= 6'd3) begin
          seq_phase++;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        if (seq_phase <= 6'd1) begin
          seq_phase++;
        end else if (int'(seq_bits) + 1 >= int'(RECOVERY_CLOCKS)) begin
          // hand over to the sensor start sequence
          seq_cmd   = CMD_SENSOR;
          seq_phase = 6'd0;
        end else begin
          seq_bits++;
          seq_phase = 6'd1;
        end
      end
    endcase
  endtask

  task automatic predict_tick(input logic [2:0] kind, input logic [7:0] tx, input logic ackl,
                              input logic sda, output levels_t lv);
    logic fin;
    logic done;
    done = 1'b0;
    if (seq_cmd == CMD_NONE) begin
      if (kind >= CMD_START && kind <= CMD_RECOVER) begin
        seq_cmd   = cmd_e_t'(kind);
        seq_phase = '0;
        seq_bits  = '0;
        seq_shift = (kind == CMD_WRITE) ? tx : 8'h00;
        seq_nack  = ackl;
        enter_step();
      end
    end else if (seq_delay > 16'd0) begin
      seq_delay--;
    end else if (seq_units > 3'd0) begin
      seq_units--;
      seq_delay = unit_ticks() - 16'd1;
    end else begin
      advance(sda, fin);
      if (fin) begin
        seq_cmd   = CMD_NONE;
        seq_phase = '0;
        done      = 1'b1;
      end else begin
        enter_step();
      end
    end
    lv      = bus_lines(seq_scl, seq_sda, seq_drv, seq_cmd != CMD_NONE);
    lv.done = done;
    lv.rx   = seq_rx;
    lv.ack  = seq_ack;
  endtask

  task automatic send_tick(input logic [2:0] kind, input logic [7:0] tx, input logic ackl,
                           input logic sda, input logic has_want, input levels_t want);
    levels_t lv;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, sda, ackl, tx};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    predict_tick(kind, tx, ackl, sda, lv);
    levels_due.push_back(has_want ? want : lv);
  endtask

  // Hold the sender until every expected result has been taken.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (levels_due.size() != 0);
  endtask

  task automatic run_out_command();
    while (seq_cmd != CMD_NONE)
      send_tick(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic set_unit_ticks(input logic [15:0] value);
    run_out_command();
    wait_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    seq_ticks = value;
  endtask

  task automatic random_ticks(input int unsigned n);
    int unsigned taken;
    logic [2:0]  kind;
    logic        ignored;
    taken = 0;
    while (taken < n) begin
      ignored = 1'b0;
      if (seq_cmd == CMD_NONE) begin
        case ($urandom_range(0, 9))
          0: kind = CMD_NONE;
          1: begin
            kind    = KIND_UNUSED;
            ignored = 1'b1;
          end
          default: kind = 3'($urandom_range(CMD_START, CMD_RECOVER));
        endcase
      end else if ($urandom_range(0, 19) == 0) begin
        // commands while busy are dropped by the block
        kind    = 3'($urandom_range(CMD_START, KIND_UNUSED));
        ignored = 1'b1;
      end else begin
        kind = CMD_NONE;
      end
      send_tick(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, '0);
      if (!ignored) taken++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < 200)
      $display("mismatch on %s at result %0d: got %0h, want %0h", what, result_count, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (levels_due.size() == 0) begin
        report_mismatch("unrequested result", out_tdata, '0);
      end else begin
        due_lv  = levels_due.pop_front();
        seen_lv = levels_t'(out_tdata);
        if (seen_lv.scl !== due_lv.scl)
          report_mismatch("scl_level", 16'(seen_lv.scl), 16'(due_lv.scl));
        if (seen_lv.sda !== due_lv.sda)
          report_mismatch("sda_level", 16'(seen_lv.sda), 16'(due_lv.sda));
        if (seen_lv.drv !== due_lv.drv)
          report_mismatch("sda_drive", 16'(seen_lv.drv), 16'(due_lv.drv));
        if (seen_lv.busy !== due_lv.busy)
          report_mismatch("busy", 16'(seen_lv.busy), 16'(due_lv.busy));
        if (seen_lv.done !== due_lv.done)
          report_mismatch("done", 16'(seen_lv.done), 16'(due_lv.done));
        if (seen_lv.rx !== due_lv.rx)
          report_mismatch("rx_byte", 16'(seen_lv.rx), 16'(due_lv.rx));
        if (seen_lv.ack !== due_lv.ack)
          report_mismatch("ack_seen", 16'(seen_lv.ack), 16'(due_lv.ack));
        if (seen_lv.pad !== due_lv.pad)
          report_mismatch("padding", 16'(seen_lv.pad), 16'(due_lv.pad));
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL i2c_master_bit_sequencer");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_NONE;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    seq_cmd     = CMD_NONE;
    seq_phase   = '0;
    seq_delay   = '0;
    seq_units   = '0;
    seq_bits    = '0;
    seq_shift   = '0;
    seq_rx      = '0;
    seq_scl     = 1'b0;
    seq_sda     = 1'b1;
    seq_drv     = 1'b1;
    seq_ack     = 1'b0;
    seq_nack    = 1'b0;
    seq_ticks   = TICKS_RESET;
    send_idle_pct = 36;
    recv_idle_pct = 86;

    // is_cfg, value, kind, tx, ack_level, sda_in, repeats, typed, typed result
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 16'd1, 1'b1,
                     bus_lines(1'b0, 1'b1, 1'b1, 1'b0)});
    plan.push_back('{1'b0, 16'd0, KIND_UNUSED, 8'hFF, 1'b1, 1'b1, 16'd1, 1'b1,
                     bus_lines(1'b0, 1'b1, 1'b1, 1'b0)});
    // start at the reset tick count: first step lasts exactly 100 ticks
    plan.push_back('{1'b0, 16'd0, CMD_START, 8'h00, 1'b0, 1'b1, 16'd1, 1'b1,
                     bus_lines(1'b1, 1'b1, 1'b1, 1'b1)});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 16'd99, 1'b1,
                     bus_lines(1'b1, 1'b1, 1'b1, 1'b1)});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 16'd1, 1'b1,
                     bus_lines(1'b1, 1'b0, 1'b1, 1'b1)});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 16'd150, 1'b0, '0});
    // a tick count of zero behaves as one
    plan.push_back('{1'b1, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_WRITE, 8'hFF, 1'b0, 1'b1, 16'd1, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 16'd80, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_WRITE, 8'h00, 1'b1, 1'b0, 16'd1, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 16'd80, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_READ, 8'h00, 1'b0, 1'b1, 16'd1, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 16'd60, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_READ, 8'hFF, 1'b1, 1'b0, 16'd1, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 16'd60, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_STOP, 8'h00, 1'b0, 1'b0, 16'd1, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 16'd8, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_SENSOR, 8'h00, 1'b0, 1'b1, 16'd1, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 16'd14, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_RECOVER, 8'h00, 1'b0, 1'b1, 16'd1, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 16'd40, 1'b0, '0});
    // a command while busy is dropped
    plan.push_back('{1'b0, 16'd0, CMD_START, 8'h00, 1'b0, 1'b1, 16'd1, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_WRITE, 8'h5A, 1'b1, 1'b0, 16'd1, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b1, 16'd6, 1'b0, '0});
    plan.push_back('{1'b1, 16'd3, CMD_NONE, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_RECOVER, 8'h00, 1'b0, 1'b0, 16'd1, 1'b0, '0});
    plan.push_back('{1'b0, 16'd0, CMD_NONE, 8'h00, 1'b0, 1'b0, 16'd100, 1'b0, '0});
    plan.push_back('{1'b1, 16'd1, CMD_NONE, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_unit_ticks(plan[i].value);
      end else begin
        repeat (plan[i].reps)
          send_tick(plan[i].kind, plan[i].tx, plan[i].ackl, plan[i].sda,
                    plan[i].has_want, plan[i].want);
      end
    end

    random_ticks(250);

    send_idle_pct = 86;
    recv_idle_pct = 36;
    set_unit_ticks(16'd2);
    random_ticks(120);
    wait_results();
    random_ticks(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_unit_ticks(16'($urandom_range(3, 8)));
    random_ticks(125);
    set_unit_ticks(16'd1);
    random_ticks(125);
    // largest tick count taken while idle: lines hold
    set_unit_ticks(16'hFFFF);
    repeat (4)
      send_tick(CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b0, '0);

    wait_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS i2c_master_bit_sequencer");
    end else begin
      $display("FAIL i2c_master_bit_sequencer");
    end
    $finish;
  end

endmodule
